// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the index seek-entry builder.
// Bodies drop out when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/aisb_pkg.sv -----
// Package for the index seek-entry builder: widths, codes, state type,
// divider interface structs and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package aisb_pkg;

    localparam int unsigned DIVIDEND_W = 64;
    localparam int unsigned DIVISOR_W  = 32;
    localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        FUNC_LEGACY         = 2'd0,
        FUNC_STANDARD       = 2'd1,
        FUNC_START_LEGACY   = 2'd2,
        FUNC_START_STANDARD = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STREAM_SELECT  = 3'd0,
        CFG_KEYFRAMES_ONLY = 3'd1,
        CFG_RATE           = 3'd2,
        CFG_SCALE          = 3'd3,
        CFG_SAMPLE_SIZE    = 3'd4,
        CFG_KEY_MASK       = 3'd5,
        CFG_NO_TIME_MASK   = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_START,
        S_MS1,
        S_MS2,
        S_TS_START,
        S_TS_WAIT,
        S_EMIT,
        S_ADV,
        S_SMP_START,
        S_SMP_WAIT,
        S_MUL_ADV,
        S_ADD
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_ctl;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_sts;

    // {valid, value} of one ASCII hex character, either case.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            res = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return res;
    endfunction

endpackage

// ----- hdl/avi_index_seek_entry_builder_top.sv -----
// Top level of the index seek-entry builder: sequencer, config registers,
// shared multiplier and output register. Depends on aisb_pkg, aisb_div and
// assert_macros.svh.
//
//   channel   direction  handshake                 word
//   input     in         i_in_valid / o_in_ready   func, tag, flags, size, offset,
//                                                  segment base and start
//   output    out        o_out_valid / i_out_ready timestamp, position, time, abs
//   config    in         i_cfg_wr_en (no wait)     index, 32-bit data
//
// A start-legacy word or a filtered legacy word is done when accepted; a start-standard
// word adds one 32x32 multiply. An entry that emits and advances with a nonzero
// sample size passes through the accept step, the ms setup, two passes of the
// radix-2 divider (timestamp, then sample count), the emit step and the advance,
// multiply and add steps; with sample size zero the second pass and the multiply
// are skipped. Reset is synchronous, active low, and restores the register reset
// values and zero running time and base. A held output word stalls the sequencer
// only at the load of the next result.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module avi_index_seek_entry_builder_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_cfg_wr_en,
    input  logic [aisb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [aisb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,

    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_func,
    input  logic [31:0]                i_chunk_tag,
    input  logic [31:0]                i_entry_flags,
    input  logic [31:0]                i_entry_size,
    input  logic [31:0]                i_entry_offset,
    input  logic [63:0]                i_segment_base,
    input  logic [31:0]                i_segment_start,

    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [31:0]         o_seek_ms,
    output logic [63:0]                o_seek_pos,
    output logic [63:0]                o_seek_time,
    output logic                       o_absolute_pos
);
    import aisb_pkg::*;

    // state and config
    t_state       r_state, n_state;
    logic [7:0]   r_stream_select, n_stream_select;
    logic         r_keyframes_only, n_keyframes_only;
    logic [31:0]  r_rate, n_rate;
    logic [31:0]  r_scale, n_scale;
    logic [31:0]  r_sample_size, n_sample_size;
    logic [31:0]  r_key_mask, n_key_mask;
    logic [31:0]  r_no_time_mask, n_no_time_mask;
    logic [63:0]  r_run_time, n_run_time;
    logic [63:0]  r_base, n_base;
    logic         r_out_valid, n_out_valid;

    // latched word and working registers
    logic         r_is_std, n_is_std;
    logic         r_advance, n_advance;
    logic [30:0]  r_size, n_size;
    logic [31:0]  r_offset, n_offset;
    logic [31:0]  r_seg_start, n_seg_start;
    logic [63:0]  r_prod, n_prod;
    logic [31:0]  r_ts, n_ts;
    logic [63:0]  r_adv, n_adv;

    // output word
    logic [31:0]  r_out_ts, n_out_ts;
    logic [63:0]  r_out_pos, n_out_pos;
    logic [63:0]  r_out_time, n_out_time;
    logic         r_out_abs, n_out_abs;

    logic         w_accept;
    logic [4:0]   w_hi, w_lo;
    logic         w_match;
    logic         w_leg_key;
    logic         w_no_time;
    logic         w_emit;
    logic [31:0]  w_mul_a;
    logic [63:0]  w_mul;
    t_div_ctl     w_div_ctl;
    t_div_sts     w_div_sts;

    aisb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .o_sts   (w_div_sts)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // legacy stream match: byte 0 is the high hex digit
    assign w_hi      = hex_digit(i_chunk_tag[7:0]);
    assign w_lo      = hex_digit(i_chunk_tag[15:8]);
    assign w_match   = w_hi[4] && w_lo[4] && ({w_hi[3:0], w_lo[3:0]} == r_stream_select);
    assign w_leg_key = |(i_entry_flags & r_key_mask);
    assign w_no_time = |(i_entry_flags & r_no_time_mask);

    // shared multiplier: segment start on a standard start, sample count otherwise;
    // a 32x32 product with zero-extended operands
    assign w_mul_a = (r_state == S_MUL_START) ? r_seg_start : w_div_sts.quotient[31:0];
    assign w_mul   = {32'b0, w_mul_a} * {32'b0, r_scale};

    always_comb begin
        n_state          = r_state;
        n_stream_select  = r_stream_select;
        n_keyframes_only = r_keyframes_only;
        n_rate           = r_rate;
        n_scale          = r_scale;
        n_sample_size    = r_sample_size;
        n_key_mask       = r_key_mask;
        n_no_time_mask   = r_no_time_mask;
        n_run_time       = r_run_time;
        n_base           = r_base;
        n_out_valid      = r_out_valid;
        n_is_std         = r_is_std;
        n_advance        = r_advance;
        n_size           = r_size;
        n_offset         = r_offset;
        n_seg_start      = r_seg_start;
        n_prod           = r_prod;
        n_ts             = r_ts;
        n_adv            = r_adv;
        n_out_ts         = r_out_ts;
        n_out_pos        = r_out_pos;
        n_out_time       = r_out_time;
        n_out_abs        = r_out_abs;
        w_emit           = 1'b0;

        w_div_ctl.start    = 1'b0;
        w_div_ctl.dividend = r_prod;
        w_div_ctl.divisor  = r_rate;

        // config writes are to arrive only while idle; the block itself does not enforce this
        if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STREAM_SELECT:  n_stream_select  = i_cfg_wdata[7:0];
                CFG_KEYFRAMES_ONLY: n_keyframes_only = i_cfg_wdata[0];
                CFG_RATE:           n_rate           = i_cfg_wdata;
                CFG_SCALE:          n_scale          = i_cfg_wdata;
                CFG_SAMPLE_SIZE:    n_sample_size    = i_cfg_wdata;
                CFG_KEY_MASK:       n_key_mask       = i_cfg_wdata;
                CFG_NO_TIME_MASK:   n_no_time_mask   = i_cfg_wdata;
                default: ;
            endcase
        end

        // drop the output word once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_is_std    = (t_func'(i_func) == FUNC_STANDARD);
                    n_size      = i_entry_size[30:0];
                    n_offset    = i_entry_offset;
                    n_seg_start = i_segment_start;
                    unique case (t_func'(i_func))
                        FUNC_START_LEGACY: begin
                            n_run_time = '0;
                        end
                        FUNC_START_STANDARD: begin
                            n_base  = i_segment_base;
                            n_state = S_MUL_START;
                        end
                        FUNC_LEGACY: begin
                            w_emit    = w_match && (!r_keyframes_only || w_leg_key);
                            n_advance = w_match && !w_no_time;
                            n_state   = w_emit ? S_MS1 : (n_advance ? S_ADV : S_IDLE);
                        end
                        FUNC_STANDARD: begin
                            w_emit    = !r_keyframes_only || !i_entry_size[31];
                            n_advance = 1'b1;
                            n_state   = w_emit ? S_MS1 : S_ADV;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL_START: begin
                n_run_time = w_mul;
                n_state    = S_IDLE;
            end
            // time * 1000 = time * 1024 - time * 16 - time * 8, mod 2^64
            S_MS1: begin
                n_prod  = (r_run_time << 10) - (r_run_time << 3);
                n_state = S_MS2;
            end
            S_MS2: begin
                n_prod  = r_prod - (r_run_time << 4);
                n_state = S_TS_START;
            end
            S_TS_START: begin
                w_div_ctl.start = 1'b1;
                n_state         = S_TS_WAIT;
            end
            S_TS_WAIT: begin
                if (w_div_sts.done) begin
                    n_ts    = w_div_sts.quotient[31:0];
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_ts    = r_ts;
                    n_out_pos   = r_is_std ? (r_base + {32'b0, r_offset}) : {32'b0, r_offset};
                    n_out_time  = r_run_time;
                    n_out_abs   = r_is_std;
                    n_state     = r_advance ? S_ADV : S_IDLE;
                end
            end
            S_ADV: begin
                if (r_sample_size == '0) begin
                    n_adv   = {32'b0, r_scale};
                    n_state = S_ADD;
                end else begin
                    n_state = S_SMP_START;
                end
            end
            S_SMP_START: begin
                w_div_ctl.start    = 1'b1;
                w_div_ctl.dividend = {33'b0, r_size};
                w_div_ctl.divisor  = r_sample_size;
                n_state            = S_SMP_WAIT;
            end
            S_SMP_WAIT: begin
                if (w_div_sts.done) begin
                    n_state = S_MUL_ADV;
                end
            end
            S_MUL_ADV: begin
                n_adv   = w_mul;
                n_state = S_ADD;
            end
            S_ADD: begin
                n_run_time = r_run_time + r_adv;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_stream_select  <= 8'd0;
            r_keyframes_only <= 1'b0;
            r_rate           <= 32'd1;
            r_scale          <= 32'd1;
            r_sample_size    <= 32'd0;
            r_key_mask       <= 32'd16;
            r_no_time_mask   <= 32'd256;
            r_run_time       <= '0;
            r_base           <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_stream_select  <= n_stream_select;
            r_keyframes_only <= n_keyframes_only;
            r_rate           <= n_rate;
            r_scale          <= n_scale;
            r_sample_size    <= n_sample_size;
            r_key_mask       <= n_key_mask;
            r_no_time_mask   <= n_no_time_mask;
            r_run_time       <= n_run_time;
            r_base           <= n_base;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_std    <= n_is_std;
        r_advance   <= n_advance;
        r_size      <= n_size;
        r_offset    <= n_offset;
        r_seg_start <= n_seg_start;
        r_prod      <= n_prod;
        r_ts        <= n_ts;
        r_adv       <= n_adv;
        r_out_ts    <= n_out_ts;
        r_out_pos   <= n_out_pos;
        r_out_time  <= n_out_time;
        r_out_abs   <= n_out_abs;
    end

    assign o_out_valid    = r_out_valid;
    assign o_seek_ms      = signed'(r_out_ts);
    assign o_seek_pos     = r_out_pos;
    assign o_seek_time    = r_out_time;
    assign o_absolute_pos = r_out_abs;

    // divider is started only when free, and finishes only where it is awaited
    `ASSERT_IMPL(a_div_start_free, i_clk, i_rst_n, w_div_ctl.start, !w_div_sts.busy)
    `ASSERT_IMPL(a_div_done_wait, i_clk, i_rst_n, w_div_sts.done, (r_state == S_TS_WAIT) || (r_state == S_SMP_WAIT))
    // a result never overwrites a word still waiting at the output
    `ASSERT_NEXT(a_emit_waits, i_clk, i_rst_n, (r_state == S_EMIT) && r_out_valid && !i_out_ready, r_state == S_EMIT)

endmodule

// ----- hdl/aisb_div.sv -----
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle. Depends on aisb_pkg.
`timescale 1ns / 1ps

module aisb_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aisb_pkg::t_div_ctl i_ctl,
    output aisb_pkg::t_div_sts o_sts
);
    import aisb_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_dsr, n_dsr;

    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;

    always_comb begin
        // shift in the next dividend bit, try to subtract
        w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        w_ge    = (w_trial >= {1'b0, r_dsr});

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_ctl.dividend;
            n_dsr  = i_ctl.divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            n_quo = {r_quo[DIVIDEND_W-2:0], w_ge};
            n_cnt = DIV_CNT_W'(r_cnt + 1'b1);
            if (r_cnt == DIV_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_sts.busy     = r_busy;
    assign o_sts.done     = r_done;
    assign o_sts.quotient = r_quo;

endmodule

// ----- sim/aisb_seek_checker.sv -----
// Checker for the index seek-entry builder: tracks config writes and accepted
// input words, predicts seek points and compares the output words in order.
// Depends on aisb_pkg for the function and register codes.
`timescale 1ns / 1ps

module aisb_seek_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_wr_en,
    input  logic [aisb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [aisb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,

    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [1:0]                      i_func,
    input  logic [31:0]                     i_chunk_tag,
    input  logic [31:0]                     i_entry_flags,
    input  logic [31:0]                     i_entry_size,
    input  logic [31:0]                     i_entry_offset,
    input  logic [63:0]                     i_segment_base,
    input  logic [31:0]                     i_segment_start,

    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic signed [31:0]              i_seek_ms,
    input  logic [63:0]                     i_seek_pos,
    input  logic [63:0]                     i_seek_time,
    input  logic                            i_absolute_pos,

    output int                              o_fail_count,
    output int                              o_pending
);
    import aisb_pkg::*;

    typedef struct packed {
        logic signed [31:0] ms;
        logic [63:0]        pos;
        logic [63:0]        stime;
        logic               absolute;
    } t_seek_point;

    t_seek_point seek_q[$];
    t_seek_point want_pt;
    t_seek_point got_pt;

    logic [7:0]  cfg_stream;
    logic        cfg_key_only;
    logic [31:0] cfg_rate;
    logic [31:0] cfg_scale;
    logic [31:0] cfg_smp;
    logic [31:0] cfg_key_mask;
    logic [31:0] cfg_nt_mask;

    logic [63:0] cur_time;
    logic [63:0] seg_base;
    int          sn;
    int          fails = 0;

    assign o_fail_count = fails;

    task automatic flag_mismatch(input string msg);
        $display("%0t MISMATCH %s", $time, msg);
        fails++;
    endtask

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    // Byte 0 is the high digit; a non-hex character names no stream.
    function automatic int stream_of_tag(input logic [31:0] tag);
        int hi;
        int lo;
        hi = hex_nibble(tag[7:0]);
        lo = hex_nibble(tag[15:8]);
        if (hi < 0 || lo < 0) return -1;
        return hi * 16 + lo;
    endfunction

    function automatic logic signed [31:0] ms_of(input logic [63:0] t);
        logic [63:0] scaled;
        logic [63:0] quo;
        scaled = t * 64'd1000;
        if (cfg_rate == 32'h0) quo = '1;
        else quo = scaled / {32'h0, cfg_rate};
        return quo[31:0];
    endfunction

    // Bit 31 of the size never takes part in the sample count.
    function automatic logic [63:0] time_step(input logic [31:0] size);
        logic [63:0] whole;
        if (cfg_smp == 32'h0) return {32'h0, cfg_scale};
        whole = {33'h0, size[30:0]} / {32'h0, cfg_smp};
        return {32'h0, cfg_scale} * whole;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_stream   = 8'h0;
            cfg_key_only = 1'b0;
            cfg_rate     = 32'd1;
            cfg_scale    = 32'd1;
            cfg_smp      = 32'd0;
            cfg_key_mask = 32'd16;
            cfg_nt_mask  = 32'd256;
            cur_time     = '0;
            seg_base     = '0;
            seek_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_STREAM_SELECT:  cfg_stream   = i_cfg_wdata[7:0];
                    CFG_KEYFRAMES_ONLY: cfg_key_only = i_cfg_wdata[0];
                    CFG_RATE:           cfg_rate     = i_cfg_wdata;
                    CFG_SCALE:          cfg_scale    = i_cfg_wdata;
                    CFG_SAMPLE_SIZE:    cfg_smp      = i_cfg_wdata;
                    CFG_KEY_MASK:       cfg_key_mask = i_cfg_wdata;
                    CFG_NO_TIME_MASK:   cfg_nt_mask  = i_cfg_wdata;
                    default: ;
                endcase
            end

            // Retire the output word first, so a stray word never claims a
            // seek point predicted at the same edge.
            if (i_out_valid && i_out_ready) begin
                got_pt.ms       = i_seek_ms;
                got_pt.pos      = i_seek_pos;
                got_pt.stime    = i_seek_time;
                got_pt.absolute = i_absolute_pos;
                if (seek_q.size() == 0) begin
                    flag_mismatch($sformatf("output word with no seek point pending: ts %0d pos %h",
                                            got_pt.ms, got_pt.pos));
                end else begin
                    want_pt = seek_q.pop_front();
                    if (got_pt.ms !== want_pt.ms)
                        flag_mismatch($sformatf("seek_ms got %0d want %0d",
                                                got_pt.ms, want_pt.ms));
                    if (got_pt.pos !== want_pt.pos)
                        flag_mismatch($sformatf("seek_pos got %h want %h",
                                                got_pt.pos, want_pt.pos));
                    if (got_pt.stime !== want_pt.stime)
                        flag_mismatch($sformatf("seek_time got %h want %h",
                                                got_pt.stime, want_pt.stime));
                    if (got_pt.absolute !== want_pt.absolute)
                        flag_mismatch($sformatf("absolute_pos got %b want %b",
                                                got_pt.absolute, want_pt.absolute));
                end
            end

            if (i_in_valid && i_in_ready) begin
                case (t_func'(i_func))
                    FUNC_START_LEGACY: cur_time = '0;
                    FUNC_START_STANDARD: begin
                        cur_time = {32'h0, i_segment_start} * {32'h0, cfg_scale};
                        seg_base = i_segment_base;
                    end
                    FUNC_LEGACY: begin
                        sn = stream_of_tag(i_chunk_tag);
                        if (sn == int'(cfg_stream)) begin
                            if (!cfg_key_only || (i_entry_flags & cfg_key_mask) != 32'h0) begin
                                want_pt.ms       = ms_of(cur_time);
                                want_pt.pos      = {32'h0, i_entry_offset};
                                want_pt.stime    = cur_time;
                                want_pt.absolute = 1'b0;
                                seek_q.push_back(want_pt);
                            end
                            if ((i_entry_flags & cfg_nt_mask) == 32'h0)
                                cur_time = cur_time + time_step(i_entry_size);
                        end
                    end
                    default: begin
                        // standard entry: bit 31 of the size marks a non-keyframe
                        if (!cfg_key_only || !i_entry_size[31]) begin
                            want_pt.ms       = ms_of(cur_time);
                            want_pt.pos      = seg_base + {32'h0, i_entry_offset};
                            want_pt.stime    = cur_time;
                            want_pt.absolute = 1'b1;
                            seek_q.push_back(want_pt);
                        end
                        cur_time = cur_time + time_step(i_entry_size);
                    end
                endcase
            end
        end
        o_pending = seek_q.size();
    end

endmodule

// ----- sim/avi_index_seek_entry_builder_top_tb.sv -----
// Testbench top for the index seek-entry builder: clock, reset, config
// writes, input words and output back-pressure, plus the verdict.
// Depends on aisb_pkg, avi_index_seek_entry_builder_top and aisb_seek_checker.
`timescale 1ns / 1ps

module avi_index_seek_entry_builder_top_tb;
    import aisb_pkg::*;

    localparam int LIMIT       = 1_000_000; // watchdog, in clock cycles
    localparam int SETTLE      = 200;       // longer than the slowest word
    localparam int HOLD_CYCLES = 1500;      // receiver hold-off for the fill test
    localparam int IDLE_PCT    = 38;        // chance of an idle cycle per side
    localparam int PHASE_WORDS = 205;

    typedef struct packed {
        t_func       func;
        logic [31:0] tag;
        logic [31:0] flags;
        logic [31:0] size;
        logic [31:0] offset;
        logic [63:0] base;
        logic [31:0] start;
    } t_index_word;

    typedef struct packed {
        logic [7:0]  stream_sel;
        logic        key_only;
        logic [31:0] rate_div;
        logic [31:0] scale_step;
        logic [31:0] smp_bytes;
        logic [31:0] key_mask;
        logic [31:0] nt_mask;
    } t_seek_cfg;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_func;
    logic [31:0]           i_chunk_tag;
    logic [31:0]           i_entry_flags;
    logic [31:0]           i_entry_size;
    logic [31:0]           i_entry_offset;
    logic [63:0]           i_segment_base;
    logic [31:0]           i_segment_start;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic signed [31:0]    o_seek_ms;
    logic [63:0]           o_seek_pos;
    logic [63:0]           o_seek_time;
    logic                  o_absolute_pos;

    int   cycles;
    int   fed;        // accepted input words
    bit   calm;       // no idling on either side while set
    logic hold_req;   // ask the receiver for its long hold-off
    int   chk_fails;
    int   chk_pending;

    avi_index_seek_entry_builder_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_chunk_tag     (i_chunk_tag),
        .i_entry_flags   (i_entry_flags),
        .i_entry_size    (i_entry_size),
        .i_entry_offset  (i_entry_offset),
        .i_segment_base  (i_segment_base),
        .i_segment_start (i_segment_start),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_seek_ms       (o_seek_ms),
        .o_seek_pos      (o_seek_pos),
        .o_seek_time     (o_seek_time),
        .o_absolute_pos  (o_absolute_pos)
    );

    aisb_seek_checker seek_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_chunk_tag     (i_chunk_tag),
        .i_entry_flags   (i_entry_flags),
        .i_entry_size    (i_entry_size),
        .i_entry_offset  (i_entry_offset),
        .i_segment_base  (i_segment_base),
        .i_segment_start (i_segment_start),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_seek_ms       (o_seek_ms),
        .i_seek_pos      (o_seek_pos),
        .i_seek_time     (o_seek_time),
        .i_absolute_pos  (o_absolute_pos),
        .o_fail_count    (chk_fails),
        .o_pending       (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a correct run ends well before this.
    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("avi_index_seek_entry_builder_top_tb failed");
        $finish;
    end

    // Receiver: drop ready at random, except in calm stretches. Once asked,
    // hold ready low for a long stretch so the block backs up into its input.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            i_out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic t_index_word mk_word(input t_func func, input logic [31:0] tag,
                                            input logic [31:0] flags, input logic [31:0] size,
                                            input logic [31:0] offset, input logic [63:0] base,
                                            input logic [31:0] start);
        t_index_word w;
        w.func   = func;
        w.tag    = tag;
        w.flags  = flags;
        w.size   = size;
        w.offset = offset;
        w.base   = base;
        w.start  = start;
        return w;
    endfunction

    function automatic t_seek_cfg mk_cfg(input logic [7:0] stream_sel, input logic key_only,
                                         input logic [31:0] rate_div, input logic [31:0] scale_step,
                                         input logic [31:0] smp_bytes, input logic [31:0] key_mask,
                                         input logic [31:0] nt_mask);
        t_seek_cfg c;
        c.stream_sel = stream_sel;
        c.key_only   = key_only;
        c.rate_div   = rate_div;
        c.scale_step = scale_step;
        c.smp_bytes  = smp_bytes;
        c.key_mask   = key_mask;
        c.nt_mask    = nt_mask;
        return c;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // Masks are mostly a single flag bit, sometimes a whole random word.
    function automatic logic [31:0] rnd_mask();
        if ($urandom_range(0, 2) == 0) return $urandom;
        return 32'h1 << $urandom_range(0, 31);
    endfunction

    function automatic t_seek_cfg random_cfg();
        t_seek_cfg c;
        c.stream_sel = 8'($urandom);
        c.key_only   = 1'($urandom_range(0, 1));
        c.rate_div   = $urandom_range(0, 1) ? $urandom_range(1, 100000) : $urandom;
        if (c.rate_div == 32'h0) c.rate_div = 32'd1;
        c.scale_step = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
        case ($urandom_range(0, 3))
            0:       c.smp_bytes = $urandom;
            1, 2:    c.smp_bytes = $urandom_range(1, 8);
            default: c.smp_bytes = 32'h0;
        endcase
        c.key_mask = rnd_mask();
        c.nt_mask  = rnd_mask();
        return c;
    endfunction

    // Mostly small chunks; now and then any 32-bit value.
    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 255);
            default: return $urandom_range(0, 1 << 20);
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return 8'h30 + {4'h0, n};
        return (upper ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
    endfunction

    // Chunk tag naming a stream: two hex digits of random case, high digit
    // in byte 0, random chunk-type characters above.
    function automatic logic [31:0] tag_for(input logic [7:0] stream_sel);
        logic [15:0] kind;
        kind = 16'($urandom);
        return {kind, hex_char(stream_sel[3:0], 1'($urandom_range(0, 1))),
                hex_char(stream_sel[7:4], 1'($urandom_range(0, 1)))};
    endfunction

    function automatic logic [31:0] legacy_flags(input t_seek_cfg c);
        logic [31:0] f;
        f = $urandom_range(0, 1) ? c.key_mask : 32'h0;
        if ($urandom_range(0, 3) == 0) f = f | c.nt_mask;
        if ($urandom_range(0, 3) == 0) f = f | $urandom;
        return f;
    endfunction

    // Offer one word, idling at random first, and wait for its acceptance.
    // Valid stays high across back-to-back words.
    task automatic send_word(input t_index_word w);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= w.func;
        i_chunk_tag     <= w.tag;
        i_entry_flags   <= w.flags;
        i_entry_size    <= w.size;
        i_entry_offset  <= w.offset;
        i_segment_base  <= w.base;
        i_segment_start <= w.start;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Drop valid, wait until the block is idle with every seek point out,
    // then hold off a little longer.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0 || !o_in_ready) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_cfg(input t_seek_cfg c);
        settle();
        put_reg(CFG_STREAM_SELECT, {24'h0, c.stream_sel});
        put_reg(CFG_KEYFRAMES_ONLY, {31'h0, c.key_only});
        put_reg(CFG_RATE, c.rate_div);
        put_reg(CFG_SCALE, c.scale_step);
        put_reg(CFG_SAMPLE_SIZE, c.smp_bytes);
        put_reg(CFG_KEY_MASK, c.key_mask);
        put_reg(CFG_NO_TIME_MASK, c.nt_mask);
        i_cfg_wr_en <= 1'b0;
    endtask

    // One setting, then runs of well-formed index sequences with random
    // content, mixed with stray words of any kind.
    task automatic run_phase(input t_seek_cfg c, input int n, input bit quiet, input bit squeeze);
        int          goal;
        int          pick;
        int          k;
        t_index_word w;
        apply_cfg(c);
        calm = quiet;
        goal = fed + n;
        while (fed < goal) begin
            if (squeeze && !hold_req && fed >= goal - (2 * n) / 3) hold_req <= 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_word(mk_word(FUNC_START_LEGACY, $urandom, $urandom, $urandom, $urandom,
                                  rnd64(), $urandom));
                fed++;
                repeat ($urandom_range(1, 12)) begin
                    k = $urandom_range(0, 9);
                    if (k < 8) w.tag = tag_for(c.stream_sel);
                    else if (k == 8) w.tag = tag_for(c.stream_sel ^ 8'($urandom_range(1, 255)));
                    else w.tag = $urandom;
                    w = mk_word(FUNC_LEGACY, w.tag, legacy_flags(c), pick_size(), $urandom,
                                rnd64(), $urandom);
                    send_word(w);
                    fed++;
                end
            end else if (pick < 90) begin
                send_word(mk_word(FUNC_START_STANDARD, $urandom, $urandom, $urandom, $urandom,
                                  rnd64(),
                                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000)));
                fed++;
                repeat ($urandom_range(1, 12)) begin
                    w = mk_word(FUNC_STANDARD, $urandom, $urandom, pick_size(), $urandom,
                                rnd64(), $urandom);
                    w.size[31] = 1'($urandom_range(0, 1));
                    send_word(w);
                    fed++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    w = mk_word(t_func'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                                $urandom, rnd64(), $urandom);
                    send_word(w);
                    fed++;
                end
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        fed      = 0;
        calm     = 1'b0;
        hold_req        <= 1'b0;
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_index     <= CFG_STREAM_SELECT;
        i_cfg_wdata     <= '0;
        i_in_valid      <= 1'b0;
        i_func          <= FUNC_LEGACY;
        i_chunk_tag     <= '0;
        i_entry_flags   <= '0;
        i_entry_size    <= '0;
        i_entry_offset  <= '0;
        i_segment_base  <= '0;
        i_segment_start <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: stream 0, all entries, rate 1, scale 1.
        // Entries before any start use the state as it stands.
        send_word(mk_word(FUNC_LEGACY, 32'h0000_3030, '0, '0, '0, '0, '0));
        send_word(mk_word(FUNC_STANDARD, '0, '0, 32'h8000_0000, '1, '0, '0));
        // standard start at the top of both ranges, then base plus offset wraps
        send_word(mk_word(FUNC_START_STANDARD, '0, '0, '0, '0, '1, '1));
        send_word(mk_word(FUNC_STANDARD, '0, '0, 32'h7FFF_FFFF, '1, '0, '0));
        // no-duration flag holds the time
        send_word(mk_word(FUNC_LEGACY, 32'h0000_3030, 32'h0000_0100, 32'h10, 32'h1234,
                          '0, '0));
        // characters just outside the digit ranges name no stream
        send_word(mk_word(FUNC_LEGACY, 32'h0000_4730, '0, '0, '0, '0, '0));
        send_word(mk_word(FUNC_LEGACY, 32'h0000_2F30, '0, '0, '0, '0, '0));
        send_word(mk_word(FUNC_LEGACY, 32'h0000_303A, '0, '0, '0, '0, '0));
        send_word(mk_word(FUNC_LEGACY, 32'hFFFF_3030, '1, '1, '1, '1, '1));
        // legacy start keeps the latched base
        send_word(mk_word(FUNC_START_LEGACY, '1, '1, '1, '1, 64'h1, '1));
        send_word(mk_word(FUNC_STANDARD, '0, '0, 32'h10, 32'h10, '0, '0));
        send_word(mk_word(FUNC_LEGACY, 32'h0000_3030, 32'h10, 32'h5, 32'h20, '0, '0));

        // Zero rate, keyframes only, largest scale, one byte per sample.
        apply_cfg(mk_cfg(8'hFF, 1'b1, 32'h0, '1, 32'h1, 32'h8000_0000, 32'h0));
        send_word(mk_word(FUNC_START_STANDARD, '0, '0, '0, '0, 64'h0123_4567_89AB_CDEF, '1));
        send_word(mk_word(FUNC_STANDARD, '0, '0, 32'h8000_0005, '0, '0, '0));
        send_word(mk_word(FUNC_STANDARD, '0, '0, 32'h0000_0005, '1, '0, '0));
        send_word(mk_word(FUNC_LEGACY, 32'h0000_6666, '0, '1, 32'h44, '0, '0));
        send_word(mk_word(FUNC_LEGACY, 32'h0000_4646, 32'h8000_0000, 32'h3, 32'h55, '0, '0));
        send_word(mk_word(FUNC_LEGACY, 32'h0000_6646, '1, 32'h3, 32'h66, '0, '0));
        send_word(mk_word(FUNC_LEGACY, 32'h0000_4746, '1, '0, '0, '0, '0));
        send_word(mk_word(FUNC_LEGACY, 32'h0000_6766, '1, '0, '0, '0, '0));
        send_word(mk_word(FUNC_START_LEGACY, '0, '0, '0, '0, '0, '0));

        // Largest rate and scale: the ms product wraps; every flag means no time.
        apply_cfg(mk_cfg(8'h9A, 1'b0, '1, '1, '1, 32'h0, '1));
        send_word(mk_word(FUNC_LEGACY, 32'h0000_4139, '0, '1, 32'h77, '0, '0));
        send_word(mk_word(FUNC_LEGACY, 32'h0000_6139, 32'h1, '1, 32'h88, '0, '0));
        send_word(mk_word(FUNC_START_STANDARD, '0, '0, '0, '0, rnd64(), '1));
        send_word(mk_word(FUNC_STANDARD, '0, '0, '1, 32'h99, '0, '0));
        send_word(mk_word(FUNC_STANDARD, '0, '0, 32'h0, 32'hAA, '0, '0));

        run_phase(mk_cfg(8'h01, 1'b0, 32'd1000, 32'd1, 32'd0, 32'd16, 32'd256),
                  PHASE_WORDS, 1'b0, 1'b0);
        // the receiver's long hold-off lands in this phase
        run_phase(mk_cfg(8'h00, 1'b1, 32'd30000, 32'd1001, 32'd0, 32'd16, 32'd256),
                  PHASE_WORDS, 1'b0, 1'b1);
        run_phase(mk_cfg(8'hA5, 1'b0, 32'd44100, 32'd1, 32'd4, 32'h10, 32'h100),
                  PHASE_WORDS, 1'b0, 1'b0);
        run_phase(mk_cfg(8'hFF, 1'b1, '1, '1, 32'd1, '1, '1), PHASE_WORDS, 1'b0, 1'b0);
        run_phase(mk_cfg(8'h5A, 1'b0, 32'd1, 32'd0, '1, 32'h0, 32'h0),
                  PHASE_WORDS, 1'b0, 1'b0);
        run_phase(random_cfg(), PHASE_WORDS, 1'b0, 1'b0);
        // a long stretch with no idling on either side
        run_phase(random_cfg(), PHASE_WORDS, 1'b1, 1'b0);
        run_phase(random_cfg(), PHASE_WORDS, 1'b0, 1'b0);

        settle();
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("avi_index_seek_entry_builder_top_tb passed");
        end else begin
            $display("avi_index_seek_entry_builder_top_tb failed");
        end
        $finish;
    end

endmodule
